/* rtl/core/terrain_hsv_false_color_mapper_defines.svh */
// ----------------------------------------------------------------------------
// terrain hsv false color mapper assertion macros
// Assertion macros shared by the mapper RTL.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_HSV_FALSE_COLOR_MAPPER_DEFINES_SVH
`define TERRAIN_HSV_FALSE_COLOR_MAPPER_DEFINES_SVH

// condition holds in the same cycle
`define THSVFC_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define THSVFC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/thsvfc_pkg.sv */
// ----------------------------------------------------------------------------
// thsvfc_pkg
// Types, widths and constants of the terrain false color mapper.
// ----------------------------------------------------------------------------
package thsvfc_pkg;

  localparam int FRAC_BITS = 12;
  localparam int FRAC_W    = 13;
  localparam int SPAN_W    = 9;
  localparam int CH_W      = 8;

  localparam longint unsigned ONE    = 64'd1 << FRAC_BITS;
  localparam longint unsigned SPAN60 = 64'd60 * ONE;
  localparam longint unsigned K_FULL = SPAN60 * ONE;
  localparam longint unsigned HUE_MAX = ONE * ((64'd1 << SPAN_W) - 64'd1);
  localparam int QMAX = int'(HUE_MAX / SPAN60);

  localparam int VN_W  = FRAC_BITS + 2;
  localparam int HUE_W = $clog2(HUE_MAX + 64'd1);
  localparam int R_W   = $clog2(SPAN60 + 64'd1);
  localparam int U_W   = $clog2(K_FULL + 64'd1);
  localparam int P_W   = VN_W + U_W;
  localparam int Q_W   = $clog2(QMAX + 1);
  localparam int OUT_SHIFT = 3 * FRAC_BITS + 3;

  localparam int SECTORS = 6;
  localparam int NCH      = 3;
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = FRAC_W;

  localparam logic [FRAC_W-1:0] SAT_RESET  = FRAC_W'(ONE);
  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(250);

  localparam logic [CH_W-1:0] DEEP_BLUE     = 8'd128;
  localparam logic [CH_W-1:0] SHALLOW_BLUE  = 8'd255;
  localparam logic [CH_W-1:0] SHALLOW_GREEN = 8'd64;

  typedef enum logic [1:0] {
    WATER_LAND    = 2'd0,
    WATER_DEEP    = 2'd1,
    WATER_SHALLOW = 2'd2,
    WATER_OTHER   = 2'd3
  } water_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SATURATION = 1'b0,
    REG_HUE_SPAN   = 1'b1
  } cfg_reg_t;

endpackage

/* rtl/core/thsvfc_pixel_if.sv */
// ----------------------------------------------------------------------------
// thsvfc_pixel_if
// Map pixel channel: valid, ready and the pixel fields.
// ----------------------------------------------------------------------------
interface thsvfc_pixel_if import thsvfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [FRAC_W-1:0] height;
  logic [FRAC_W-1:0] temperature;
  logic [1:0]        water_class;

  modport source (output valid, mode, height, temperature, water_class, input ready);
  modport sink (input valid, mode, height, temperature, water_class, output ready);
endinterface

/* rtl/core/thsvfc_color_if.sv */
// ----------------------------------------------------------------------------
// thsvfc_color_if
// Color channel: valid, ready and the three channel bytes.
// ----------------------------------------------------------------------------
interface thsvfc_color_if import thsvfc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink (input valid, blue, green, red, output ready);
endinterface

/* rtl/core/terrain_hsv_false_color_mapper.sv */
// ----------------------------------------------------------------------------
// terrain_hsv_false_color_mapper
// Maps a height / temperature / water pixel to a 24-bit false color by
// hsv to rgb conversion in a five stage pipeline.
// ----------------------------------------------------------------------------
// One pixel request is taken every clock while ready is high. The five
// register stages (clamp and hue product, sector split, saturation
// products, value products, channel scaling) each hold their item when the
// next stage is full, so a stalled color output fills the bubbles first
// and only then lowers ready. The user must write saturation and hue span
// through the config port only while idle; the block does not enforce it.
module terrain_hsv_false_color_mapper
  import thsvfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  thsvfc_pixel_if.sink          pixel,
  thsvfc_color_if.source        color
);

`include "terrain_hsv_false_color_mapper_defines.svh"

  localparam int NSTG = 5;

  logic [FRAC_W-1:0] saturation;
  logic [SPAN_W-1:0] hue_span;

  logic [NSTG:1]   v;
  logic [NSTG+1:1] en;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= SAT_RESET;
      hue_span   <= SPAN_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_SATURATION: saturation <= wr_data[FRAC_W-1:0];
        REG_HUE_SPAN:   hue_span   <= wr_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables
  always_comb begin
    en[NSTG+1] = color.ready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign pixel.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= pixel.valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: clamp, value and hue
  logic [FRAC_W-1:0]          h_c, t_c, s_c, t_inv;
  logic [FRAC_W+SPAN_W-1:0]   hue_prod;
  logic [VN_W-1:0]            vn_c;
  logic                       deep_c, shal_c;

  always_comb begin
    h_c = (pixel.height > FRAC_W'(ONE)) ? FRAC_W'(ONE) : pixel.height;
    t_c = (pixel.temperature > FRAC_W'(ONE)) ? FRAC_W'(ONE) : pixel.temperature;
    s_c = (saturation > FRAC_W'(ONE)) ? FRAC_W'(ONE) : saturation;
    t_inv = FRAC_W'(ONE) - t_c;
    hue_prod = {{SPAN_W{1'b0}}, t_inv} * {{FRAC_W{1'b0}}, hue_span};
    vn_c = pixel.mode ? {h_c, 1'b0} : (VN_W'(ONE) + VN_W'(h_c));
    deep_c = pixel.mode && (water_t'(pixel.water_class) == WATER_DEEP);
    shal_c = pixel.mode && (water_t'(pixel.water_class) == WATER_SHALLOW);
  end

  logic [VN_W-1:0]   s1_vn;
  logic [HUE_W-1:0]  s1_hue;
  logic [FRAC_W-1:0] s1_s;
  logic              s1_deep, s1_shal;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_vn   <= vn_c;
      s1_hue  <= hue_prod[HUE_W-1:0];
      s1_s    <= s_c;
      s1_deep <= deep_c;
      s1_shal <= shal_c;
    end
  end

  // stage 2: sector and position within it
  logic [QMAX-1:0]  ge;
  logic [Q_W-1:0]   q;
  logic [HUE_W-1:0] rem;
  logic [2:0]       sector_c;

  always_comb begin
    for (int k = 1; k <= QMAX; k++) begin
      ge[k-1] = s1_hue >= HUE_W'(longint'(k) * SPAN60);
    end
    q = Q_W'($countones(ge));
    rem = s1_hue - (HUE_W'(q) * HUE_W'(SPAN60));
    sector_c = (q >= Q_W'(SECTORS)) ? 3'(q - Q_W'(SECTORS)) : 3'(q);
  end

  logic [VN_W-1:0]   s2_vn;
  logic [R_W-1:0]    s2_r;
  logic [2:0]        s2_sector;
  logic [FRAC_W-1:0] s2_s;
  logic              s2_deep, s2_shal;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_vn     <= s1_vn;
      s2_r      <= rem[R_W-1:0];
      s2_sector <= sector_c;
      s2_s      <= s1_s;
      s2_deep   <= s1_deep;
      s2_shal   <= s1_shal;
    end
  end

  // stage 3: channel weights times saturation
  logic [R_W-1:0]        up, full;
  logic [R_W-1:0]        g [NCH];
  logic [FRAC_W+R_W-1:0] sg_c [NCH];

  always_comb begin
    full = R_W'(SPAN60);
    up = full - s2_r;
    case (s2_sector)
      3'd0: begin
        g[CH_RED] = '0;    g[CH_GREEN] = up;   g[CH_BLUE] = full;
      end
      3'd1: begin
        g[CH_RED] = s2_r;  g[CH_GREEN] = '0;   g[CH_BLUE] = full;
      end
      3'd2: begin
        g[CH_RED] = full;  g[CH_GREEN] = '0;   g[CH_BLUE] = up;
      end
      3'd3: begin
        g[CH_RED] = full;  g[CH_GREEN] = s2_r; g[CH_BLUE] = '0;
      end
      3'd4: begin
        g[CH_RED] = up;    g[CH_GREEN] = full; g[CH_BLUE] = '0;
      end
      default: begin
        g[CH_RED] = '0;    g[CH_GREEN] = full; g[CH_BLUE] = s2_r;
      end
    endcase
    for (int i = 0; i < NCH; i++) begin
      sg_c[i] = {{R_W{1'b0}}, s2_s} * {{FRAC_W{1'b0}}, g[i]};
    end
  end

  logic [VN_W-1:0] s3_vn;
  logic [U_W-1:0]  s3_sg [NCH];
  logic            s3_deep, s3_shal;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_vn   <= s2_vn;
      s3_deep <= s2_deep;
      s3_shal <= s2_shal;
      for (int i = 0; i < NCH; i++) begin
        s3_sg[i] <= sg_c[i][U_W-1:0];
      end
    end
  end

  // stage 4: value times remaining weight
  logic [U_W-1:0] u_c [NCH];
  logic [P_W-1:0] p_c [NCH];

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      u_c[i] = U_W'(K_FULL) - s3_sg[i];
      p_c[i] = {{U_W{1'b0}}, s3_vn} * {{VN_W{1'b0}}, u_c[i]};
    end
  end

  logic [P_W-1:0] s4_p [NCH];
  logic           s4_deep, s4_shal;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_deep <= s3_deep;
      s4_shal <= s3_shal;
      for (int i = 0; i < NCH; i++) begin
        s4_p[i] <= p_c[i];
      end
    end
  end

  // stage 5: scale by 255 and pick water colors
  logic [P_W+4:0]  scaled [NCH];
  logic [CH_W-1:0] ch_c [NCH];
  logic [CH_W-1:0] blue, green, red;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      scaled[i] = {s4_p[i], 4'b0000} + (P_W+5)'(s4_p[i]);
      ch_c[i] = scaled[i][OUT_SHIFT+CH_W-1:OUT_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      if (s4_deep) begin
        blue  <= DEEP_BLUE;
        green <= '0;
        red   <= '0;
      end else if (s4_shal) begin
        blue  <= SHALLOW_BLUE;
        green <= SHALLOW_GREEN;
        red   <= '0;
      end else begin
        blue  <= ch_c[CH_BLUE];
        green <= ch_c[CH_GREEN];
        red   <= ch_c[CH_RED];
      end
    end
  end

  assign color.valid = v[NSTG];
  assign color.blue  = blue;
  assign color.green = green;
  assign color.red   = red;

  `THSVFC_ASSERT_NEXT(a_accept_fills, clk, rst, pixel.valid && pixel.ready, v[1], "accepted request lost at stage 1")
  `THSVFC_ASSERT_SAME(a_sector_range, clk, rst, v[2], s2_sector < 3'(SECTORS), "sector out of range")
  `THSVFC_ASSERT_SAME(a_sg_bound, clk, rst, v[3], (s3_sg[CH_BLUE] <= U_W'(K_FULL)) && (s3_sg[CH_GREEN] <= U_W'(K_FULL)) && (s3_sg[CH_RED] <= U_W'(K_FULL)), "weight product above full scale")
  `THSVFC_ASSERT_NEXT(a_stall_holds, clk, rst, v[3] && !en[3], v[3] && $stable(s3_vn), "stalled stage dropped its item")
  `THSVFC_ASSERT_NEXT(a_deep_color, clk, rst, v[4] && en[5] && s4_deep, (blue == DEEP_BLUE) && (green == '0) && (red == '0), "deep water color wrong")

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terrain false color mapper. Pixel requests go
// in with random bursts and gaps while the color side, in some phases, stalls
// in runs. Every returned color is checked in order against a stored value
// for the fixed directed rows and otherwise a bit-exact predictor of the hsv
// conversion and the water overrides, across a range of saturation and hue span settings.
// ----------------------------------------------------------------------------
module tb_top
  import thsvfc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FRAC_W-1:0] FULL = FRAC_W'(ONE);
  localparam int N_PHASES   = 10;
  localparam int PHASE_REQS = 115;
  localparam int HOLD_LEN   = 250;
  localparam int MAX_PRINTS = 30;

  typedef struct packed {
    logic              mode;
    logic [FRAC_W-1:0] height;
    logic [FRAC_W-1:0] temperature;
    water_t            water;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } color_t;

  typedef struct packed {
    pixel_t px;
    logic   fixed;
    color_t want;
  } dir_row_t;

  typedef struct {
    int unsigned seq;
    color_t      want;
  } pending_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  thsvfc_pixel_if pix ();
  thsvfc_color_if col ();

  terrain_hsv_false_color_mapper u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pixel    (pix),
    .color    (col)
  );

  always #5ns clk = ~clk;

  pending_t color_q[$];
  dir_row_t dir_rows[18];

  logic [FRAC_W-1:0] sat_reg;
  logic [SPAN_W-1:0] span_reg;

  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_compound;
  int unsigned n_water;
  int unsigned n_cfg;
  int unsigned n_errors;

  int burst_left;
  bit no_idle;
  int rx_style;
  int hold_pending;
  int hold_left;
  int run_left;
  bit run_ready;

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  function automatic longint unsigned clamp_frac(input longint unsigned x);
    return (x > ONE) ? ONE : x;
  endfunction

  function automatic logic [CH_W-1:0] scale_channel(input longint unsigned vn,
                                                     input longint unsigned s,
                                                     input longint unsigned g);
    return CH_W'((64'd255 * vn * (K_FULL - s * g)) / (64'd2 * ONE * K_FULL));
  endfunction

  function automatic color_t predict_color(input pixel_t px);
    longint unsigned h, t, s, vn, hue, sector, r, gr, gg, gb;
    color_t c;
    h = clamp_frac(px.height);
    t = clamp_frac(px.temperature);
    s = clamp_frac(sat_reg);
    if (px.mode && px.water == WATER_DEEP) begin
      c = '{DEEP_BLUE, 8'd0, 8'd0};
      return c;
    end
    if (px.mode && px.water == WATER_SHALLOW) begin
      c = '{SHALLOW_BLUE, SHALLOW_GREEN, 8'd0};
      return c;
    end
    vn = px.mode ? 2 * h : ONE + h;
    hue = (ONE - t) * span_reg;
    sector = (hue / SPAN60) % SECTORS;
    r = hue % SPAN60;
    case (sector)
      0: begin gr = 0;      gg = SPAN60 - r; gb = SPAN60;     end
      1: begin gr = r;      gg = 0;          gb = SPAN60;     end
      2: begin gr = SPAN60; gg = 0;          gb = SPAN60 - r; end
      3: begin gr = SPAN60; gg = r;          gb = 0;          end
      4: begin gr = SPAN60 - r; gg = SPAN60; gb = 0;          end
      default: begin gr = 0; gg = SPAN60;    gb = r;          end
    endcase
    c.blue  = scale_channel(vn, s, gb);
    c.green = scale_channel(vn, s, gg);
    c.red   = scale_channel(vn, s, gr);
    return c;
  endfunction

  function automatic logic [FRAC_W-1:0] rand_frac();
    case ($urandom_range(0, 9))
      6, 7: return FRAC_W'($urandom_range(0, 8191));
      8: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return FRAC_W'(1);
          2: return FULL - 1'b1;
          3: return FULL;
          4: return FULL + 1'b1;
          default: return '1;
        endcase
      end
      9: return FRAC_W'($urandom_range(3800, 4096));
      default: return FRAC_W'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.mode        = 1'($urandom_range(0, 1));
    px.height      = rand_frac();
    px.temperature = rand_frac();
    px.water       = water_t'($urandom_range(0, 3));
    return px;
  endfunction

  // offer one request, hold it until taken, then queue its color
  task automatic send_pixel(input pixel_t px, input logic fixed, input color_t want);
    pending_t p;
    pix.valid       <= 1'b1;
    pix.mode        <= px.mode;
    pix.height      <= px.height;
    pix.temperature <= px.temperature;
    pix.water_class <= px.water;
    do @(posedge clk); while (!pix.ready);
    p.seq  = n_sent;
    p.want = fixed ? want : predict_color(px);
    color_q.push_back(p);
    n_sent++;
    if (px.mode) n_compound++;
    if (px.mode && (px.water == WATER_DEEP || px.water == WATER_SHALLOW)) n_water++;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_colors();
    pix.valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_SATURATION) sat_reg = data;
    else span_reg = SPAN_W'(data);
    n_cfg++;
    @(posedge clk);
  endtask

  // color side: long hold-off on request, otherwise always ready or runs of ready and stall
  always @(posedge clk) begin
    if (rst) begin
      col.ready <= 1'b0;
      hold_left = 0;
      run_left  = 0;
    end else if (hold_left != 0) begin
      col.ready <= 1'b0;
      hold_left--;
    end else if (hold_pending != 0) begin
      col.ready <= 1'b0;
      hold_left = hold_pending - 1;
      hold_pending = 0;
    end else if (rx_style == 0) begin
      col.ready <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_ready = !run_ready;
        if (rx_style == 1) run_left = run_ready ? $urandom_range(1, 16) : $urandom_range(1, 3);
        else run_left = run_ready ? $urandom_range(1, 4) : $urandom_range(1, 10);
      end
      col.ready <= run_ready;
      run_left--;
    end
  end

  always @(posedge clk) begin
    pending_t p;
    if (!rst && col.valid && col.ready) begin
      if (color_q.size() == 0) begin
        report_mismatch($sformatf("color b=%0d g=%0d r=%0d with no request pending",
                                  col.blue, col.green, col.red));
      end else begin
        p = color_q.pop_front();
        n_checked++;
        if (col.blue !== p.want.blue)
          report_mismatch($sformatf("request %0d blue %0d, want %0d",
                                    p.seq, col.blue, p.want.blue));
        if (col.green !== p.want.green)
          report_mismatch($sformatf("request %0d green %0d, want %0d",
                                    p.seq, col.green, p.want.green));
        if (col.red !== p.want.red)
          report_mismatch($sformatf("request %0d red %0d, want %0d",
                                    p.seq, col.red, p.want.red));
      end
    end
  end

  initial begin
    #2ms;
    $display("timeout with %0d colors outstanding", color_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [FRAC_W-1:0] sat_set;
    logic [SPAN_W-1:0] span_set;
    rst             = 1'b1;
    wr_en           = 1'b0;
    wr_index        = REG_SATURATION;
    wr_data         = '0;
    pix.valid       = 1'b0;
    pix.mode        = 1'b0;
    pix.height      = '0;
    pix.temperature = '0;
    pix.water_class = WATER_LAND;
    sat_reg         = SAT_RESET;
    span_reg        = SPAN_RESET;
    burst_left      = 0;
    no_idle         = 1'b0;
    rx_style        = 1;
    hold_pending    = 0;

    // reset settings: full saturation, 250 degree span
    dir_rows = '{
      '{'{1'b0, FULL, FULL, WATER_LAND},      1'b1, '{8'd0, 8'd0, 8'd255}},
      '{'{1'b0, 13'd0, FULL, WATER_LAND},     1'b1, '{8'd0, 8'd0, 8'd127}},
      '{'{1'b1, 13'd0, 13'd0, WATER_LAND},    1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{1'b1, 13'd1234, 13'd777, WATER_DEEP},    1'b1, '{8'd128, 8'd0, 8'd0}},
      '{'{1'b1, 13'd3000, 13'd100, WATER_SHALLOW}, 1'b1, '{8'd255, 8'd64, 8'd0}},
      '{'{1'b0, FULL, FULL, WATER_DEEP},      1'b1, '{8'd0, 8'd0, 8'd255}},
      '{'{1'b1, 13'd0, 13'd0, WATER_OTHER},   1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{1'b1, 13'h1fff, 13'h1fff, WATER_LAND},    1'b1, '{8'd0, 8'd0, 8'd255}},
      '{'{1'b1, 13'h1fff, 13'h1fff, WATER_SHALLOW}, 1'b1, '{8'd255, 8'd64, 8'd0}},
      '{'{1'b0, 13'd0, FULL, WATER_SHALLOW},  1'b1, '{8'd0, 8'd0, 8'd127}},
      '{'{1'b1, 13'd2048, FULL, WATER_LAND},  1'b1, '{8'd0, 8'd0, 8'd127}},
      '{'{1'b0, 13'h1fff, 13'd0, WATER_LAND}, 1'b0, '0},
      '{'{1'b0, 13'd0, 13'd0, WATER_OTHER},   1'b0, '0},
      '{'{1'b1, FULL, 13'd0, WATER_LAND},     1'b0, '0},
      '{'{1'b1, FULL, 13'd2048, WATER_OTHER}, 1'b0, '0},
      '{'{1'b0, 13'd4095, 13'd4095, WATER_LAND},   1'b0, '0},
      '{'{1'b0, 13'd1, 13'd1, WATER_DEEP},    1'b0, '0},
      '{'{1'b0, 13'd6000, 13'd1000, WATER_OTHER},  1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].px, dir_rows[i].fixed, dir_rows[i].want);
      pace_sender();
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin sat_set = FULL;           span_set = 9'd250; end
        1: begin sat_set = '0;             span_set = 9'd359; end
        2: begin sat_set = '1;             span_set = 9'd511; end
        3: begin sat_set = FULL - 1'b1;    span_set = 9'd360; end
        4: begin sat_set = FRAC_W'(1);     span_set = 9'd0;   end
        5: begin sat_set = FRAC_W'(2048);  span_set = 9'd300; end
        6: begin sat_set = FULL + 1'b1;    span_set = 9'd120; end
        default: begin
          sat_set  = rand_frac();
          span_set = SPAN_W'($urandom_range(0, 511));
        end
      endcase
      // config only changes once every color is back
      drain_colors();
      write_reg(REG_SATURATION, sat_set);
      write_reg(REG_HUE_SPAN, CFG_DATA_W'(span_set));
      rx_style = p % 3;
      no_idle  = (p == 2) || (p == 4);
      if (p == 4) hold_pending = HOLD_LEN;
      for (int n = 0; n < PHASE_REQS; n++) begin
        send_pixel(rand_pixel(), 1'b0, '0);
        pace_sender();
      end
    end

    drain_colors();
    rx_style = 0;
    repeat (20) @(posedge clk);
    if (color_q.size() != 0)
      report_mismatch($sformatf("%0d colors never returned", color_q.size()));

    $display("sent %0d pixel requests (%0d compound, %0d water overrides), checked %0d colors",
             n_sent, n_compound, n_water, n_checked);
    $display("covered %0d register writes incl. saturated and wrapping settings, %0d errors",
             n_cfg, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
